// ----- rtl/efs_pkg.sv -----
// Package for the earliest-free-server scheduler.
// Field widths, payload structs and the inter-cell token/update types.
// No dependencies; used by efs_cell and earliest_free_server_scheduler.
package efs_pkg;

  localparam int ARR_W     = 40;
  localparam int DUR_W     = 32;
  localparam int END_W     = 48;
  localparam int OUT_IDX_W = 4;
  localparam int CFG_W     = 5;
  // wide enough for any server index up to the largest supported server count
  localparam int SRV_IDX_W = 8;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
  localparam logic [END_W-1:0] END_MAX   = {END_W{1'b1}};

  typedef struct packed {
    logic [ARR_W-1:0] arrival_time;
    logic [DUR_W-1:0] duration;
  } in_item_t;

  typedef struct packed {
    logic [END_W-1:0]     job_end;
    logic [OUT_IDX_W-1:0] server_index;
    logic                 saturated;
  } out_item_t;

  // running minimum handed from cell to cell
  typedef struct packed {
    logic                 valid;
    logic [END_W-1:0]     free_time;
    logic [SRV_IDX_W-1:0] idx;
  } token_t;

  // finish-time write broadcast to every cell
  typedef struct packed {
    logic                 en;
    logic [SRV_IDX_W-1:0] idx;
    logic [END_W-1:0]     free_time;
  } upd_t;

endpackage

// ----- rtl/earliest_free_server_scheduler.sv -----
// Earliest-free-server job scheduler, top level.
// Chain of efs_cell instances plus dispatch control; depends on efs_pkg.
//
// Usage:
//   in_*  : job transaction (arrival_time, duration), valid/ready.
//   out_* : result transaction (job_end, server_index, saturated), valid/ready.
//   cfg_* : cfg_we writes servers_in_use from cfg_wdata; 0 acts
//           as 1, values above MAX_SERVERS act as MAX_SERVERS.
// A job is accepted in the idle state and a token walks the chain of
// MAX_SERVERS cells, one cell per cycle, picking the earliest finish time
// (lowest index on a tie). The start time is registered from the token; then
// the duration is added, the sum saturated and the output register loaded
// while the chosen cell takes the new finish time. The next job is taken
// only after that load, once control is back in the idle state.
// A waiting result does not block the next job's walk; a job only stalls at
// its final step while the previous result still sits unaccepted.
// Reset clears all finish times to zero and sets servers_in_use to 16.
module earliest_free_server_scheduler #(
  parameter int MAX_SERVERS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  efs_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output efs_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [efs_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_SERVERS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_CALC = 3'b100
  } state_t;

  state_t                        state_r, state_nxt;
  logic [efs_pkg::CFG_W-1:0]     cfg_r;
  logic [CNT_W-1:0]              act_cnt;
  logic [MAX_SERVERS-1:0]        in_use;
  efs_pkg::token_t               tok [MAX_SERVERS+1];
  efs_pkg::upd_t                 upd;
  efs_pkg::in_item_t             item_r;
  logic [efs_pkg::END_W-1:0]     start_r;
  logic [efs_pkg::SRV_IDX_W-1:0] best_idx_r;
  logic [efs_pkg::END_W:0]       sum;
  logic                          sat;
  logic [efs_pkg::END_W-1:0]     job_end;
  logic                          in_acc;
  logic                          load_out;
  logic                          out_valid_r;
  efs_pkg::out_item_t            out_r;
  efs_pkg::token_t               tok_last;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign load_out = (state_r == ST_CALC) && (!out_valid_r || out_ready);
  assign tok_last = tok[MAX_SERVERS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= efs_pkg::CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (cfg_r == '0) begin
      act_cnt = CNT_W'(1);
    end else if (32'(cfg_r) > 32'(MAX_SERVERS)) begin
      act_cnt = CNT_W'(MAX_SERVERS);
    end else begin
      act_cnt = CNT_W'(cfg_r);
    end
  end

  assign tok[0].valid     = in_acc;
  assign tok[0].free_time = '0;
  assign tok[0].idx       = '0;

  genvar k;
  generate
    for (k = 0; k < MAX_SERVERS; k++) begin : g_cell
      assign in_use[k] = 32'(k) < 32'(act_cnt);
      efs_cell #(
        .IDX (k)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_use_i (in_use[k]),
        .tok_i    (tok[k]),
        .upd_i    (upd),
        .tok_o    (tok[k+1])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN: if (tok_last.valid) state_nxt = ST_CALC;
      ST_CALC: if (load_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
  end

  // job starts at the later of arrival and the chosen server's finish time
  always_ff @(posedge clk) begin
    if ((state_r == ST_SCAN) && tok_last.valid) begin
      best_idx_r <= tok_last.idx;
      if (efs_pkg::END_W'(item_r.arrival_time) > tok_last.free_time) begin
        start_r <= efs_pkg::END_W'(item_r.arrival_time);
      end else begin
        start_r <= tok_last.free_time;
      end
    end
  end

  // start < 2^48 and duration < 2^32, so the top sum bit flags overflow
  assign sum     = {1'b0, start_r} + (efs_pkg::END_W + 1)'(item_r.duration);
  assign sat     = sum[efs_pkg::END_W];
  assign job_end = sat ? efs_pkg::END_MAX : sum[efs_pkg::END_W-1:0];

  assign upd.en        = load_out;
  assign upd.idx       = best_idx_r;
  assign upd.free_time = job_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r.job_end      <= job_end;
      out_r.server_index <= best_idx_r[efs_pkg::OUT_IDX_W-1:0];
      out_r.saturated    <= sat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // the token only reaches the end of the chain while a job is being scanned
  a_tok_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok_last.valid |-> (state_r == ST_SCAN))
    else $error("token left the cell chain outside a scan");

  // every finish-time write comes with a result presented on the next cycle
  a_upd_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    upd.en |=> out_valid_r)
    else $error("finish time written without a result");

  a_sat_clips: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.saturated) |-> (out_r.job_end == efs_pkg::END_MAX))
    else $error("saturated result not clipped to maximum");

  // no new job is taken while a scan is still walking the chain
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("job accepted during a scan");

endmodule

// ----- rtl/efs_cell.sv -----
// One server cell: holds that server's finish time and passes the running
// minimum token on to the next cell each cycle.
// Depends on efs_pkg.
module efs_cell #(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_use_i,
  input  efs_pkg::token_t tok_i,
  input  efs_pkg::upd_t   upd_i,
  output efs_pkg::token_t tok_o
);

  logic [efs_pkg::END_W-1:0] free_r;
  efs_pkg::token_t           tok_r;
  logic                      take_own;

  // strict less-than keeps the lower index on a tie; cell 0 seeds the token
  assign take_own = (IDX == 0) || (in_use_i && (free_r < tok_i.free_time));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= '0;
    end else if (upd_i.en && (upd_i.idx == efs_pkg::SRV_IDX_W'(IDX))) begin
      free_r <= upd_i.free_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_i.valid;
    end
    if (take_own) begin
      tok_r.free_time <= free_r;
      tok_r.idx       <= efs_pkg::SRV_IDX_W'(IDX);
    end else begin
      tok_r.free_time <= tok_i.free_time;
      tok_r.idx       <= tok_i.idx;
    end
  end

  assign tok_o = tok_r;

endmodule

// ----- bench/efs_checker.sv -----
// Checker for the earliest-free-server scheduler: watches the job, result and config ports.
// It predicts each result, compares it with the DUT output and counts mismatches.
// Depends on efs_pkg.
`timescale 1ns / 100ps
module efs_checker #(
  parameter int NUM_SERVERS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  efs_pkg::in_item_t         in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  efs_pkg::out_item_t        out_data,
  input  logic                      cfg_we,
  input  logic [efs_pkg::CFG_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        pending
);

  logic [efs_pkg::END_W-1:0] srv_free [NUM_SERVERS];
  logic [efs_pkg::CFG_W-1:0] server_count;
  efs_pkg::out_item_t        expected_q [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] efs_checker: %s", $time, msg);
    fail_count++;
  endtask

  // Picks the earliest free server among the active ones and books the job on it.
  function automatic efs_pkg::out_item_t schedule_job(input efs_pkg::in_item_t job);
    int                        active;
    int                        best;
    logic [efs_pkg::END_W-1:0] start;
    logic [efs_pkg::END_W:0]   total;
    efs_pkg::out_item_t        res;
    active = int'(server_count);
    if (active == 0) active = 1;
    if (active > NUM_SERVERS) active = NUM_SERVERS;
    best = 0;
    for (int i = 1; i < active; i++) begin
      if (srv_free[i] < srv_free[best]) best = i;
    end
    start = srv_free[best];
    if (efs_pkg::END_W'(job.arrival_time) > start) start = efs_pkg::END_W'(job.arrival_time);
    total = {1'b0, start} + (efs_pkg::END_W + 1)'(job.duration);
    res.saturated    = total[efs_pkg::END_W];
    res.job_end      = total[efs_pkg::END_W] ? efs_pkg::END_MAX
                                             : total[efs_pkg::END_W-1:0];
    res.server_index = efs_pkg::OUT_IDX_W'(best);
    srv_free[best] = res.job_end;
    return res;
  endfunction

  always @(posedge clk) begin
    efs_pkg::out_item_t want;
    if (!rst_n) begin
      server_count = efs_pkg::CFG_RESET;
      foreach (srv_free[i]) srv_free[i] = '0;
      expected_q.delete();
    end else begin
      if (cfg_we) server_count = cfg_wdata;
      if (in_valid && in_ready) expected_q.push_back(schedule_job(in_data));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result transaction with no job outstanding");
        end else begin
          want = expected_q.pop_front();
          if (out_data.job_end !== want.job_end)
            report_mismatch($sformatf("job_end got %h want %h",
                                      out_data.job_end, want.job_end));
          if (out_data.server_index !== want.server_index)
            report_mismatch($sformatf("server_index got %0d want %0d",
                                      out_data.server_index, want.server_index));
          if (out_data.saturated !== want.saturated)
            report_mismatch($sformatf("saturated got %b want %b",
                                      out_data.saturated, want.saturated));
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top for earliest_free_server_scheduler: clock, reset, job and ready stimulus.
// Instantiates the DUT and efs_checker; depends on efs_pkg.
`timescale 1ns / 100ps
module tb_top;

  localparam int NUM_SERVERS    = 16;
  localparam int SETTLE         = NUM_SERVERS + 4;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_JOBS     = 130;
  // max-duration jobs stacked on one server, pushing its finish time far out
  localparam int RAMP_JOBS      = 40;

  localparam logic [efs_pkg::ARR_W-1:0] ARR_MAX = '1;
  localparam logic [efs_pkg::DUR_W-1:0] DUR_MAX = '1;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  efs_pkg::in_item_t         in_data;
  logic                      out_valid;
  logic                      out_ready;
  efs_pkg::out_item_t        out_data;
  logic                      cfg_we;
  logic [efs_pkg::CFG_W-1:0] cfg_wdata;

  int                        fail_count;
  int                        pending;
  int                        idle_cycles;
  int                        hold_requests;
  int                        hold_served;
  logic                      quiet;
  logic [efs_pkg::ARR_W-1:0] job_clock;

  always #5 clk = ~clk;

  earliest_free_server_scheduler #(.MAX_SERVERS(NUM_SERVERS)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  efs_checker #(.NUM_SERVERS(NUM_SERVERS)) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic efs_pkg::in_item_t job_of(input logic [efs_pkg::ARR_W-1:0] arrival,
                                               input logic [efs_pkg::DUR_W-1:0] dur);
    efs_pkg::in_item_t job;
    job.arrival_time = arrival;
    job.duration     = dur;
    return job;
  endfunction

  // Mostly arrivals that creep forward with short jobs so servers tie and queue up.
  function automatic efs_pkg::in_item_t random_job();
    logic [efs_pkg::ARR_W-1:0] arrival;
    logic [efs_pkg::DUR_W-1:0] dur;
    case ($urandom_range(0, 19))
      0:       arrival = efs_pkg::ARR_W'({$urandom, $urandom});
      1:       arrival = '0;
      2:       arrival = ARR_MAX;
      default: begin
        job_clock = job_clock + efs_pkg::ARR_W'($urandom_range(0, 40));
        arrival   = job_clock;
      end
    endcase
    case ($urandom_range(0, 7))
      0:       dur = $urandom;
      1:       dur = '0;
      2:       dur = DUR_MAX;
      3:       dur = $urandom_range(0, 100000);
      default: dur = $urandom_range(0, 60);
    endcase
    return job_of(arrival, dur);
  endfunction

  // Called at a falling edge; returns at a falling edge after the transaction.
  task automatic push_job(input efs_pkg::in_item_t job);
    in_data  <= job;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_servers(input logic [efs_pkg::CFG_W-1:0] count);
    wait_drained();
    repeat (SETTLE) @(negedge clk);
    cfg_wdata <= count;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Result side: random short stalls, plus long hold-offs on request.
  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left  = 0;
    hold_left   = 0;
    hold_served = 0;
    out_ready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [efs_pkg::CFG_W-1:0] phase_counts [9];
    int                        p;
    int                        i;
    phase_counts  = '{5'd1, 5'd16, 5'd2, 5'd31, 5'd5, 5'd0, 5'd17, 5'd9, 5'd16};
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = efs_pkg::CFG_RESET;
    quiet         = 1'b0;
    hold_requests = 0;
    job_clock     = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // all servers free at zero: ties go to the lowest index
    push_job(job_of('0, '0));
    push_job(job_of('0, 32'd5));
    push_job(job_of('0, 32'd5));
    push_job(job_of(40'd10, '0));
    push_job(job_of(ARR_MAX, DUR_MAX));
    push_job(job_of(ARR_MAX, '0));
    push_job(job_of(40'd7, 32'd3));
    // zero count acts as one server
    write_servers(5'd0);
    push_job(job_of(40'd3, 32'd1));
    push_job(job_of(40'd100, 32'd7));
    // count above the server total is clamped
    write_servers(5'd31);
    push_job(job_of('0, '0));
    push_job(job_of('0, '0));
    // shrink, then grow back: idle servers keep their old finish times
    write_servers(5'd2);
    push_job(job_of(40'd50, 32'd1));
    push_job(job_of(40'd50, 32'd1));
    write_servers(5'd17);
    push_job(job_of('0, 32'd2));
    push_job(job_of('0, 32'd2));
    push_job(job_of(40'd20, 32'd4));

    for (p = 0; p < 9; p++) begin
      write_servers(p == 7 ? efs_pkg::CFG_W'($urandom_range(0, 31)) : phase_counts[p]);
      for (i = 0; i < PHASE_JOBS; i++) begin
        // long result hold-off while jobs keep coming, to back up the input side
        if (p == 0 && i == 10) hold_requests <= hold_requests + 1;
        if ($urandom_range(0, 199) == 0) wait_drained();
        push_job(random_job());
      end
    end

    // Single server, back-to-back max-duration jobs stacking up its finish time.
    write_servers(5'd1);
    quiet <= 1'b1;
    push_job(job_of(ARR_MAX, DUR_MAX));
    for (i = 0; i < RAMP_JOBS; i++)
      push_job(job_of(efs_pkg::ARR_W'({$urandom, $urandom}), DUR_MAX));
    // zero duration at time zero: starts and ends at the stored finish time
    push_job(job_of('0, '0));

    write_servers(5'd16);
    for (i = 0; i < PHASE_JOBS; i++) push_job(random_job());

    wait_drained();
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/efs_pkg.sv
rtl/efs_cell.sv
rtl/earliest_free_server_scheduler.sv
bench/efs_checker.sv
bench/tb_top.sv
